// ===== src/bd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bd_pkg
// Shared types and fixed field widths for the bounded deque.
// ----------------------------------------------------------------------------
package bd_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_BACK  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_BACK   = 2'd3
    } bd_kind_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } bd_status_t;

    typedef enum logic [0:0] {
        S_IDLE   = 1'b0,
        S_FINISH = 1'b1
    } bd_state_t;

endpackage
`default_nettype wire

// ===== src/bd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bd_ram
// Slot store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bd_ram #(
    parameter int DEPTH = 16,
    parameter int IW    = 4
) (
    input  wire logic                      aclk,
    input  wire logic                      we,
    input  wire logic [IW-1:0]             waddr,
    input  wire logic [bd_pkg::VALUE_W-1:0] wdata,
    input  wire logic                      re,
    input  wire logic [IW-1:0]             raddr,
    output logic      [bd_pkg::VALUE_W-1:0] rdata
);
    import bd_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Hold read data while no read is issued.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== src/bounded_deque.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque
// Double-ended queue of signed 32-bit values in a ring of DEPTH slots.
// ----------------------------------------------------------------------------
// Each request on the s_ channel is one operation (push front, push back,
// pop front, pop back, selected by s_tuser) and gives exactly one result on
// the m_ channel: status, removed value, count after the operation and the
// values now at the front and back (zero when empty). A push into a full
// queue is dropped with status full; a pop from an empty queue changes
// nothing and reports status empty. An operation has an accept step and a
// finish step: in the accept cycle the ring pointers advance and the slot
// memory is written (push) or read (pop); in the finish step the registered
// read data of the slot memory settles the new front or back value and the
// result is loaded into the output register. The front and back values are
// cached in registers, so a pop reads only the one slot that becomes the new
// end. The output register lets a new request be accepted while a result
// waits on m_tready; the finish step of the next request holds until it is taken.
// ----------------------------------------------------------------------------
module bounded_deque #(
    parameter int DEPTH = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Request channel
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [31:0] value
    input  wire logic [1:0]   s_tuser,   // [1:0] kind
    // Result channel
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [103:0] m_tdata,   // [31:0] removed_value, [36:32] count,
                                         // [68:37] front_value,
                                         // [100:69] back_value, [103:101] zero
    output logic      [1:0]   m_tuser    // [1:0] status
);
    import bd_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_CNT  = CW'(1);

    // Ring state and cached end values
    bd_state_t          state_reg, state_next;
    logic [IW-1:0]      front_reg, front_next;
    logic [IW-1:0]      back_reg, back_next;
    logic [CW-1:0]      occ_reg, occ_next;
    logic [VALUE_W-1:0] front_val_reg, front_val_next;
    logic [VALUE_W-1:0] back_val_reg, back_val_next;

    // Pending operation between accept and finish
    bd_status_t         stat_reg, stat_next;
    logic [VALUE_W-1:0] removed_reg, removed_next;
    logic               fetch_front_reg, fetch_front_next;
    logic               fetch_back_reg, fetch_back_next;

    // Output register
    logic               out_valid_reg;
    bd_status_t         out_stat_reg;
    logic [VALUE_W-1:0] out_removed_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [VALUE_W-1:0] out_front_reg;
    logic [VALUE_W-1:0] out_back_reg;

    // Slot memory access
    logic               mem_we, mem_re;
    logic [IW-1:0]      mem_waddr, mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    logic               accept;
    logic               out_load;
    logic               empty, full;
    logic [IW-1:0]      front_inc, front_dec, back_inc, back_dec;
    logic [VALUE_W-1:0] fin_front, fin_back;
    logic [OW-1:0]      count_ext;
    bd_kind_t           kind;

    assign kind  = bd_kind_t'(s_tuser);
    assign empty = (occ_reg == '0);
    assign full  = (occ_reg == FULL_CNT);

    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + IW'(1);
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - IW'(1);
    assign back_inc  = (back_reg == LAST_IDX) ? '0 : back_reg + IW'(1);
    assign back_dec  = (back_reg == '0) ? LAST_IDX : back_reg - IW'(1);

    bd_ram #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (s_tdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Sequencer: accept in idle, finish once the output register is free.
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // Operation decode in the accept cycle: advance pointers, issue slot access.
    always_comb begin
        front_next       = front_reg;
        back_next        = back_reg;
        occ_next         = occ_reg;
        front_val_next   = front_val_reg;
        back_val_next    = back_val_reg;
        stat_next        = stat_reg;
        removed_next     = removed_reg;
        fetch_front_next = fetch_front_reg;
        fetch_back_next  = fetch_back_reg;
        mem_we           = 1'b0;
        mem_waddr        = front_reg;
        mem_re           = 1'b0;
        mem_raddr        = front_inc;

        if (accept) begin
            stat_next        = STAT_DONE;
            removed_next     = '0;
            fetch_front_next = 1'b0;
            fetch_back_next  = 1'b0;
            unique case (kind)
                KIND_PUSH_FRONT: begin
                    if (full) begin
                        stat_next = STAT_FULL;
                    end else begin
                        mem_we         = 1'b1;
                        mem_waddr      = front_dec;
                        front_next     = front_dec;
                        front_val_next = s_tdata;
                        occ_next       = occ_reg + ONE_CNT;
                        if (empty) begin
                            back_next     = front_dec;
                            back_val_next = s_tdata;
                        end
                    end
                end
                KIND_PUSH_BACK: begin
                    if (full) begin
                        stat_next = STAT_FULL;
                    end else begin
                        mem_we        = 1'b1;
                        back_val_next = s_tdata;
                        occ_next      = occ_reg + ONE_CNT;
                        if (empty) begin
                            mem_waddr      = front_reg;
                            back_next      = front_reg;
                            front_val_next = s_tdata;
                        end else begin
                            mem_waddr = back_inc;
                            back_next = back_inc;
                        end
                    end
                end
                KIND_POP_FRONT: begin
                    if (empty) begin
                        stat_next = STAT_EMPTY;
                    end else begin
                        removed_next = front_val_reg;
                        front_next   = front_inc;
                        occ_next     = occ_reg - ONE_CNT;
                        if (occ_reg == ONE_CNT) begin
                            front_val_next = '0;
                            back_val_next  = '0;
                        end else begin
                            // Fetch the slot that becomes the new front.
                            mem_re           = 1'b1;
                            mem_raddr        = front_inc;
                            fetch_front_next = 1'b1;
                        end
                    end
                end
                KIND_POP_BACK: begin
                    if (empty) begin
                        stat_next = STAT_EMPTY;
                    end else begin
                        removed_next = back_val_reg;
                        back_next    = back_dec;
                        occ_next     = occ_reg - ONE_CNT;
                        if (occ_reg == ONE_CNT) begin
                            front_val_next = '0;
                            back_val_next  = '0;
                        end else begin
                            // Fetch the slot that becomes the new back.
                            mem_re          = 1'b1;
                            mem_raddr       = back_dec;
                            fetch_back_next = 1'b1;
                        end
                    end
                end
                default: begin
                    stat_next = STAT_DONE;
                end
            endcase
        end else if (out_load) begin
            // Fold fetched slot into the cached end value.
            front_val_next   = fin_front;
            back_val_next    = fin_back;
            fetch_front_next = 1'b0;
            fetch_back_next  = 1'b0;
        end
    end

    assign fin_front = fetch_front_reg ? mem_rdata : front_val_reg;
    assign fin_back  = fetch_back_reg  ? mem_rdata : back_val_reg;
    assign count_ext = OW'(occ_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            front_reg       <= '0;
            back_reg        <= '0;
            occ_reg         <= '0;
            front_val_reg   <= '0;
            back_val_reg    <= '0;
            fetch_front_reg <= 1'b0;
            fetch_back_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            front_reg       <= front_next;
            back_reg        <= back_next;
            occ_reg         <= occ_next;
            front_val_reg   <= front_val_next;
            back_val_reg    <= back_val_next;
            fetch_front_reg <= fetch_front_next;
            fetch_back_reg  <= fetch_back_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        stat_reg    <= stat_next;
        removed_reg <= removed_next;
        if (out_load) begin
            out_stat_reg    <= stat_reg;
            out_removed_reg <= removed_reg;
            out_count_reg   <= count_ext[COUNT_W-1:0];
            out_front_reg   <= fin_front;
            out_back_reg    <= fin_back;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_stat_reg;
    assign m_tdata  = {3'b000, out_back_reg, out_front_reg, out_count_reg, out_removed_reg};

endmodule
`default_nettype wire
